@@ sv/tbfc_pkg.sv @@
// Shared constants for the two-body frame cosine unit.
`timescale 1ns / 1ps
package tbfc_pkg;
  localparam int MOMENTUM_BITS_DEF = 24;
  localparam int COS_FRAC_BITS_DEF = 15;
  localparam int CHUNK_BITS = 26;
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MASS_LOW = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MASS_HIGH = 1'b1;
endpackage

@@ sv/tbfc_mul.sv @@
// Two-stage signed multiplier built from registered chunk products.
`timescale 1ns / 1ps
module tbfc_mul
  import tbfc_pkg::*;
#(
  parameter int WA = 32,
  parameter int WB = 32,
  parameter int CW = CHUNK_BITS
) (
  input  logic                       clk,
  input  logic signed [WA-1:0]       a,
  input  logic signed [WB-1:0]       b,
  output logic signed [WA+WB-1:0]    p
);
  localparam int NA = (WA + CW - 1) / CW;
  localparam int NB = (WB + CW - 1) / CW;
  localparam int XA = NA * CW;
  localparam int XB = NB * CW;
  localparam int PW = XA + XB;

  logic signed [XA-1:0]     ax;
  logic signed [XB-1:0]     bx;
  logic signed [CW:0]       ca [NA];
  logic signed [CW:0]       cb [NB];
  logic signed [2*CW+1:0]   pp [NA*NB];
  logic signed [PW-1:0]     acc;

  assign ax = XA'(a);
  assign bx = XB'(b);

  for (genvar i = 0; i < NA; i++) begin : g_ca
    if (i == NA - 1) begin : g_top
      assign ca[i] = $signed({ax[i*CW+CW-1], ax[i*CW +: CW]});
    end else begin : g_low
      assign ca[i] = $signed({1'b0, ax[i*CW +: CW]});
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_cb
    if (j == NB - 1) begin : g_top
      assign cb[j] = $signed({bx[j*CW+CW-1], bx[j*CW +: CW]});
    end else begin : g_low
      assign cb[j] = $signed({1'b0, bx[j*CW +: CW]});
    end
  end

  for (genvar i = 0; i < NA; i++) begin : g_ppi
    for (genvar j = 0; j < NB; j++) begin : g_ppj
      always_ff @(posedge clk) begin
        pp[i*NB+j] <= ca[i] * cb[j];
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (PW'(pp[i*NB+j]) <<< ((i + j) * CW));
      end
    end
  end

  always_ff @(posedge clk) begin
    p <= acc[WA+WB-1:0];
  end
endmodule

@@ sv/two_body_frame_cos_theta_unit.sv @@
// Top level of the two-body frame cosine unit.
// The unit takes one event per clock: pulse start with both four-momenta on the
// input ports; busy is always low, so every start is accepted. Events whose pair
// mass lies outside [mass_low, mass_high), or whose squared mass is not positive,
// give no result. Every other event gives one result on cos_angle and degenerate,
// marked by done for exactly one cycle, after a delay that does not depend on
// MOMENTUM_BITS. Throughput is one event per cycle; the latency is set by the
// chain of chunked multipliers (four of them) and one square-root stage per
// result bit. Results leave in the order the events came in.
// The mass window is written through cfg_valid/cfg_ready/cfg_index/cfg_data,
// which is always ready; write it only while no event is in flight.
// Synchronous reset empties the pipeline and sets the window to its full range.
// The receiver cannot stall: each result request is taken in the cycle it shows.
`timescale 1ns / 1ps
module two_body_frame_cos_theta_unit
  import tbfc_pkg::*;
#(
  parameter int MOMENTUM_BITS = MOMENTUM_BITS_DEF,
  parameter int COS_FRAC_BITS = COS_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [MOMENTUM_BITS-2:0]      h_energy,
  input  logic signed [MOMENTUM_BITS-1:0] h_px,
  input  logic signed [MOMENTUM_BITS-1:0] h_py,
  input  logic signed [MOMENTUM_BITS-1:0] h_pz,
  input  logic [MOMENTUM_BITS-2:0]      j_energy,
  input  logic signed [MOMENTUM_BITS-1:0] j_px,
  input  logic signed [MOMENTUM_BITS-1:0] j_py,
  input  logic signed [MOMENTUM_BITS-1:0] j_pz,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [MOMENTUM_BITS-2:0]      cfg_data,
  output logic                          done,
  output logic signed [COS_FRAC_BITS:0] cos_angle,
  output logic                          degenerate
);
  localparam int M    = MOMENTUM_BITS;
  localparam int F    = COS_FRAC_BITS;
  localparam int EW   = M - 1;
  localparam int QW   = M + 1;
  localparam int DW   = 2 * M + 4;
  localparam int LW   = 3 * M + 5;
  localparam int NW   = 4 * M + 7;
  localparam int EEW  = 6 * M + 12;
  localparam int DDW  = EEW + DW;
  localparam int NNW  = 2 * NW;
  localparam int W    = 8 * M + 2 * F + 20;
  localparam int KW   = F + 1;
  localparam int NSTG = F + 15;
  localparam int KILL = 5;
  localparam logic [KW-1:0] COS_MAX = KW'((2 ** F) - 1);

  logic [EW-1:0]       mass_low;
  logic [EW-1:0]       mass_high;
  logic [2*EW-1:0]     ml_sq;
  logic [2*EW-1:0]     mh_sq;
  logic [NSTG:1]       vld;
  logic                pass4;

  logic signed [M-1:0]  hin [4];
  logic signed [M-1:0]  jin [4];
  logic signed [QW-1:0] q1 [4];
  logic signed [M-1:0]  h1 [4];
  logic signed [M-1:0]  j1 [4];

  logic signed [2*QW-1:0]   pqq [4];
  logic signed [QW+M-1:0]   pqj [4];
  logic signed [QW+M-1:0]   pqh [4];

  logic [4*M-1:0]       hv_d [3];
  logic [4*M-1:0]       jv_d [3];
  logic [2*QW-1:0]      qez_d [6];
  logic signed [DW-1:0] q2_4, a4, b4;
  logic signed [DW-1:0] z2_d [7];

  logic signed [DW+M-1:0]  pa [4];
  logic signed [DW+M-1:0]  pb [4];
  logic signed [LW-1:0]    ell7 [4];

  logic signed [LW+QW-1:0] pn0, pn1;
  logic signed [2*LW-1:0]  pee [4];
  logic signed [NW-1:0]    n10;
  logic signed [EEW-1:0]   ee10;
  logic                    neg11, neg12;

  logic signed [DDW-1:0]   d12;
  logic signed [NNW-1:0]   nn12;

  logic [W-1:0]  rr [F+2];
  logic [W-1:0]  ss [F+2];
  logic [W-1:0]  dm [F+2];
  logic [KW-1:0] kk [F+2];
  logic          dg [F+2];
  logic          ng [F+2];

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  assign done = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      mass_low <= '0;
      mass_high <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MASS_LOW: mass_low <= cfg_data;
        REG_MASS_HIGH: mass_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ml_sq <= mass_low * mass_low;
    mh_sq <= mass_high * mass_high;
  end

  assign pass4 = (q2_4 > 0) && (q2_4 >= $signed(DW'(ml_sq))) && (q2_4 < $signed(DW'(mh_sq)));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld[1] <= start && !busy;
      for (int i = 2; i <= NSTG; i++) begin
        vld[i] <= (i == KILL) ? (vld[i-1] && pass4) : vld[i-1];
      end
    end
  end

  always_comb begin
    hin[0] = $signed(M'(h_energy));
    hin[1] = h_px;
    hin[2] = h_py;
    hin[3] = h_pz;
    jin[0] = $signed(M'(j_energy));
    jin[1] = j_px;
    jin[2] = j_py;
    jin[3] = j_pz;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      q1[i] <= QW'(hin[i]) + QW'(jin[i]);
      h1[i] <= hin[i];
      j1[i] <= jin[i];
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_dot
    tbfc_mul #(.WA(QW), .WB(QW)) u_qq (.clk(clk), .a(q1[i]), .b(q1[i]), .p(pqq[i]));
    tbfc_mul #(.WA(QW), .WB(M)) u_qj (.clk(clk), .a(q1[i]), .b(j1[i]), .p(pqj[i]));
    tbfc_mul #(.WA(QW), .WB(M)) u_qh (.clk(clk), .a(q1[i]), .b(h1[i]), .p(pqh[i]));
  end

  always_ff @(posedge clk) begin
    hv_d[0] <= {h1[3], h1[2], h1[1], h1[0]};
    jv_d[0] <= {j1[3], j1[2], j1[1], j1[0]};
    hv_d[1] <= hv_d[0];
    jv_d[1] <= jv_d[0];
    hv_d[2] <= hv_d[1];
    jv_d[2] <= jv_d[1];
    qez_d[0] <= {q1[3], q1[0]};
    for (int i = 1; i < 6; i++) begin
      qez_d[i] <= qez_d[i-1];
    end
    q2_4 <= DW'(pqq[0]) - DW'(pqq[1]) - DW'(pqq[2]) - DW'(pqq[3]);
    a4 <= DW'(pqj[0]) - DW'(pqj[1]) - DW'(pqj[2]) - DW'(pqj[3]);
    b4 <= DW'(pqh[0]) - DW'(pqh[1]) - DW'(pqh[2]) - DW'(pqh[3]);
    z2_d[0] <= DW'(pqq[3]) - DW'(pqq[0]);
    for (int i = 1; i < 7; i++) begin
      z2_d[i] <= z2_d[i-1];
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_ell
    tbfc_mul #(.WA(DW), .WB(M)) u_pa (
      .clk(clk), .a(a4), .b($signed(hv_d[2][i*M +: M])), .p(pa[i])
    );
    tbfc_mul #(.WA(DW), .WB(M)) u_pb (
      .clk(clk), .a(b4), .b($signed(jv_d[2][i*M +: M])), .p(pb[i])
    );
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      ell7[i] <= LW'(pa[i]) - LW'(pb[i]);
    end
  end

  tbfc_mul #(.WA(LW), .WB(QW)) u_n0 (
    .clk(clk), .a(ell7[0]), .b($signed(qez_d[5][2*QW-1:QW])), .p(pn0)
  );
  tbfc_mul #(.WA(LW), .WB(QW)) u_n1 (
    .clk(clk), .a(ell7[3]), .b($signed(qez_d[5][QW-1:0])), .p(pn1)
  );
  for (genvar i = 0; i < 4; i++) begin : g_sq
    tbfc_mul #(.WA(LW), .WB(LW)) u_sq (.clk(clk), .a(ell7[i]), .b(ell7[i]), .p(pee[i]));
  end

  always_ff @(posedge clk) begin
    n10 <= NW'(pn0) - NW'(pn1);
    ee10 <= EEW'(pee[0]) - EEW'(pee[1]) - EEW'(pee[2]) - EEW'(pee[3]);
    neg11 <= n10[NW-1];
    neg12 <= neg11;
  end

  tbfc_mul #(.WA(EEW), .WB(DW)) u_d (.clk(clk), .a(ee10), .b(z2_d[6]), .p(d12));
  tbfc_mul #(.WA(NW), .WB(NW)) u_nn (.clk(clk), .a(n10), .b(n10), .p(nn12));

  always_ff @(posedge clk) begin
    rr[0] <= W'($unsigned(nn12)) << (2 * F);
    ss[0] <= '0;
    kk[0] <= '0;
    dm[0] <= W'($unsigned(d12));
    dg[0] <= (d12 <= 0);
    ng[0] <= neg12;
  end

  for (genvar s = 0; s <= F; s++) begin : g_root
    localparam int BIT = F - s;
    logic [W-1:0] inc;
    assign inc = (ss[s] << (BIT + 1)) + (dm[s] << (2 * BIT));
    always_ff @(posedge clk) begin
      if (rr[s] >= inc) begin
        rr[s+1] <= rr[s] - inc;
        ss[s+1] <= ss[s] + (dm[s] << BIT);
        kk[s+1] <= kk[s] | (KW'(1) << BIT);
      end else begin
        rr[s+1] <= rr[s];
        ss[s+1] <= ss[s];
        kk[s+1] <= kk[s];
      end
      dm[s+1] <= dm[s];
      dg[s+1] <= dg[s];
      ng[s+1] <= ng[s];
    end
  end

  always_ff @(posedge clk) begin
    if (dg[F+1]) begin
      cos_angle <= '0;
      degenerate <= 1'b1;
    end else if (ng[F+1]) begin
      cos_angle <= $signed(~kk[F+1] + KW'(1));
      degenerate <= 1'b0;
    end else if (kk[F+1][F]) begin
      cos_angle <= $signed(COS_MAX);
      degenerate <= 1'b0;
    end else begin
      cos_angle <= $signed(kk[F+1]);
      degenerate <= 1'b0;
    end
  end
endmodule

@@ dv/frame_cos_checker.sv @@
// Checker for the two-body frame cosine unit: predicts each event's result and compares.
`timescale 1ns / 1ps
module frame_cos_checker
  import tbfc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic [22:0]             h_energy,
  input  logic signed [23:0]      h_px,
  input  logic signed [23:0]      h_py,
  input  logic signed [23:0]      h_pz,
  input  logic [22:0]             j_energy,
  input  logic signed [23:0]      j_px,
  input  logic signed [23:0]      j_py,
  input  logic signed [23:0]      j_pz,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [22:0]             cfg_data,
  input  logic                    done,
  input  logic signed [15:0]      cos_angle,
  input  logic                    degenerate,
  output int                      mismatches,
  output int                      pending
);
  typedef logic signed [383:0] wide_t;
  typedef struct packed {
    logic signed [15:0] cosine;
    logic               degen;
  } cos_result_t;

  logic [22:0] window_low;
  logic [22:0] window_high;
  cos_result_t expected_cos[$];

  function automatic wide_t minkowski(input wide_t a[4], input wide_t b[4]);
    return a[0] * b[0] - a[1] * b[1] - a[2] * b[2] - a[3] * b[3];
  endfunction

  function automatic bit predict_cos(output cos_result_t res);
    wide_t ph[4], pj[4], q[4], ell[4];
    wide_t q2, lo, hi, a, b, n, z2, d, t, ck, lhs;
    logic [16:0] k, cand;
    logic signed [17:0] val;
    ph[0] = wide_t'({1'b0, h_energy});
    ph[1] = wide_t'(h_px);
    ph[2] = wide_t'(h_py);
    ph[3] = wide_t'(h_pz);
    pj[0] = wide_t'({1'b0, j_energy});
    pj[1] = wide_t'(j_px);
    pj[2] = wide_t'(j_py);
    pj[3] = wide_t'(j_pz);
    for (int i = 0; i < 4; i++) q[i] = ph[i] + pj[i];
    q2 = minkowski(q, q);
    lo = wide_t'({1'b0, window_low});
    hi = wide_t'({1'b0, window_high});
    lo = lo * lo;
    hi = hi * hi;
    if (q2 <= 0 || q2 < lo || q2 >= hi) return 0;
    a = minkowski(q, pj);
    b = minkowski(q, ph);
    for (int i = 0; i < 4; i++) ell[i] = a * ph[i] - b * pj[i];
    n = ell[0] * q[3] - ell[3] * q[0];
    z2 = q[3] * q[3] - q[0] * q[0];
    d = minkowski(ell, ell) * z2;
    if (d <= 0) begin
      res.cosine = '0;
      res.degen = 1'b1;
      return 1;
    end
    t = (n < 0) ? -n : n;
    t = (t * t) <<< (2 * COS_FRAC_BITS_DEF);
    k = '0;
    for (int bt = COS_FRAC_BITS_DEF; bt >= 0; bt--) begin
      cand = k | (17'd1 << bt);
      ck = wide_t'({1'b0, cand});
      lhs = ck * ck * d;
      if (lhs <= t) k = cand;
    end
    if (n < 0) begin
      val = -$signed({1'b0, k});
    end else begin
      if (k > 17'd32767) k = 17'd32767;
      val = $signed({1'b0, k});
    end
    res.cosine = val[15:0];
    res.degen = 1'b0;
    return 1;
  endfunction

  assign pending = expected_cos.size();

  always @(posedge clk) begin
    cos_result_t res;
    cos_result_t want;
    if (rst) begin
      window_low <= '0;
      window_high <= 23'h7FFFFF;
      expected_cos.delete();
      mismatches <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MASS_LOW) window_low <= cfg_data;
        else if (cfg_index == REG_MASS_HIGH) window_high <= cfg_data;
      end
      if (done) begin
        if (expected_cos.size() == 0) begin
          $display("%0t: unexpected result cos %0d degenerate %0b", $time,
                   cos_angle, degenerate);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_cos.pop_front();
          if (want.cosine !== cos_angle || want.degen !== degenerate) begin
            $display("%0t: expected cos %0d degenerate %0b, got cos %0d degenerate %0b",
                     $time, want.cosine, want.degen, cos_angle, degenerate);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (start && !busy && predict_cos(res)) expected_cos.push_back(res);
    end
  end
endmodule

@@ dv/testbench.sv @@
// Stimulus and verdict for the two-body frame cosine unit.
`timescale 1ns / 1ps
module testbench;
  import tbfc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [22:0] h_energy = '0, j_energy = '0;
  logic signed [23:0] h_px = '0, h_py = '0, h_pz = '0;
  logic signed [23:0] j_px = '0, j_py = '0, j_pz = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_MASS_LOW;
  logic [22:0] cfg_data = '0;
  logic done;
  logic signed [15:0] cos_angle;
  logic degenerate;
  int mismatches, pending;
  int cycles = 0;
  int idle_pct = 0;

  always #4 clk = ~clk;

  two_body_frame_cos_theta_unit dut (.*);
  frame_cos_checker scoreboard (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_event(input logic [22:0] he, input logic signed [23:0] hx,
                            input logic signed [23:0] hy, input logic signed [23:0] hz,
                            input logic [22:0] je, input logic signed [23:0] jx,
                            input logic signed [23:0] jy, input logic signed [23:0] jz);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    h_energy <= he; h_px <= hx; h_py <= hy; h_pz <= hz;
    j_energy <= je; j_px <= jx; j_py <= jy; j_pz <= jz;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic settle;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_window(input logic [22:0] lo, input logic [22:0] hi);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MASS_LOW;
    cfg_data <= lo;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_MASS_HIGH;
    cfg_data <= hi;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [23:0] spread(input int e);
    return 24'(int'($urandom_range(0, e)) - e / 2);
  endfunction

  // Mostly timelike particles at varied scales, plus raw noise and parallel pairs.
  task automatic random_event;
    int he, je, sc, mode;
    logic signed [23:0] hx, hy, hz;
    mode = $urandom_range(0, 99);
    if (mode < 20) begin
      send_event(23'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                 23'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
    end else begin
      sc = $urandom_range(4, 23);
      he = $urandom & ((1 << sc) - 1);
      je = $urandom & ((1 << $urandom_range(4, 23)) - 1);
      hx = spread(he);
      hy = spread(he);
      hz = spread(he);
      if (mode < 30) send_event(23'(he), hx, hy, hz, 23'(he), hx, hy, hz);
      else if (mode < 40) send_event(23'(he), 24'sd0, 24'sd0, hz,
                                     23'(je), 24'sd0, 24'sd0, spread(je));
      else send_event(23'(he), hx, hy, hz, 23'(je), spread(je), spread(je), spread(je));
    end
  endtask

  initial begin
    logic [22:0] lows[6] = '{0, 23'h7FFFFF, 0, 23'd4096, 0, 23'd100};
    logic [22:0] highs[6] = '{23'h7FFFFF, 23'h7FFFFF, 0, 23'h200000, 23'h7FFFFF, 23'h40000};
    int counts[6] = '{320, 60, 60, 340, 520, 500};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_event(0, 0, 0, 0, 0, 0, 0, 0);
    send_event(23'h7FFFFF, 0, 0, 0, 23'h7FFFFF, 0, 0, 0);
    send_event(23'h7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
               23'h7FFFFF, -24'sh800000, -24'sh800000, -24'sh800000);
    send_event(23'h7FFFFF, -24'sh800000, 24'sh7FFFFF, -24'sh800000,
               23'h7FFFFF, 24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF);
    send_event(1000, 100, 200, 300, 1000, 100, 200, 300);
    send_event(1000, 0, 0, 600, 1000, 0, 0, -600);
    send_event(1000, 0, 0, 600, 800, 0, 0, 300);
    send_event(5000, 1000, 0, 0, 5000, -1000, 0, 0);
    send_event(5000, 0, 1000, 4000, 5000, 0, -1000, -4000);
    send_event(256, 0, 0, 0, 0, 0, 0, 0);
    send_event(1, 0, 0, 0, 1, 0, 0, 0);
    send_event(23'h400000, 24'sh100000, 24'sh200000, 24'sh300000,
               23'h300000, -24'sh100000, 24'sh050000, -24'sh200000);
    send_event(100, 0, 0, 200, 100, 0, 0, 0);
    send_event(3000, 1, 2, 2999, 4000, -1, -2, -3999);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      write_window(lows[ph], highs[ph]);
      idle_pct = (ph < 2) ? 8 : (ph < 4) ? 74 : 0;
      for (int i = 0; i < counts[ph]; i++) random_event();
      settle();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
